@@ src/fis_pkg.sv @@
// Shared types and constants for the frame interval statistics block.
// No dependencies; imported by every module of the block.
package fis_pkg;

    localparam int WINDOW_DEF = 10;
    localparam int STAMP_W    = 32;
    localparam int AGE_W      = 8;
    localparam int FILL_W     = 4;

    localparam logic ACTION_STAMP = 1'b0;
    localparam logic ACTION_READ  = 1'b1;

    // Per-transaction command from the control logic to the history ring.
    typedef struct packed {
        logic take;   // an input transaction is accepted this cycle
        logic push;   // a new interval is written into the ring
        logic read;   // a history entry is looked up
    } ring_cmd_t;

endpackage

@@ src/frame_interval_stats_unit.sv @@
// Frame interval statistics: running min/max of timestamp intervals plus a history ring.
// Depends on fis_pkg and fis_history_ring.
//
// Usage:
//   Input channel (in_valid/in_ready) carries action, now_us and age_index.
//   Action 0 delivers a loop timestamp; from the second one on, the interval
//   to the previous timestamp updates the minimum, the maximum and the ring.
//   Action 1 reads the ring entry at age_index, counted from the oldest.
//   Output channel (out_valid/out_ready) returns one result per input
//   transaction: min_interval, max_interval, fill_count and history_value.
//   out_valid rises in the cycle after acceptance. The ring is read
//   through a single synchronous read port, and the result register can
//   be drained in the same cycle that the next transaction is accepted,
//   so one transaction per cycle is sustained while out_ready stays high.
//   When the receiver stalls, the result is held and in_ready drops until
//   the result is taken. Reset clears the statistics, the fill count and
//   the pointers; ring contents are left as they are and are never returned
//   before being written.
module frame_interval_stats_unit
    import fis_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [STAMP_W-1:0] now_us,
    input  logic [AGE_W-1:0]   age_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAMP_W-1:0] min_interval,
    output logic [STAMP_W-1:0] max_interval,
    output logic [FILL_W-1:0]  fill_count,
    output logic [STAMP_W-1:0] history_value
);

    localparam int CNT_W = $clog2(WINDOW+1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [STAMP_W-1:0] last_reg;
    logic               started_reg;
    logic [STAMP_W-1:0] min_reg;
    logic [STAMP_W-1:0] min_next;
    logic [STAMP_W-1:0] max_reg;
    logic [STAMP_W-1:0] max_next;
    logic [STAMP_W-1:0] interval;
    logic               accept;
    logic               out_take;
    ring_cmd_t          cmd;
    logic [CNT_W-1:0]   held;

    assign out_take = (state_reg == ST_HOLD) && out_ready;
    assign in_ready = (state_reg == ST_IDLE) || out_take;
    assign accept   = in_valid && in_ready;

    assign interval = now_us - last_reg;

    assign cmd.take = accept;
    assign cmd.push = accept && (action == ACTION_STAMP) && started_reg;
    assign cmd.read = accept && (action == ACTION_READ);

    // A minimum of zero is taken to mean none has been seen yet.
    assign min_next = ((min_reg == '0) || (interval < min_reg)) ? interval : min_reg;
    assign max_next = (interval > max_reg) ? interval : max_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_take && !accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            last_reg    <= '0;
            started_reg <= 1'b0;
            min_reg     <= '0;
            max_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (action == ACTION_STAMP))
            begin
                last_reg    <= now_us;
                started_reg <= 1'b1;
            end
            if (cmd.push)
            begin
                min_reg <= min_next;
                max_reg <= max_next;
            end
        end
    end

    fis_history_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .wr_data (interval),
        .rd_age  (age_index),
        .rd_data (history_value),
        .held    (held)
    );

    // Statistics only change on an accepted transaction, so while a result
    // is held they still show the values as of that transaction.
    assign out_valid    = (state_reg == ST_HOLD);
    assign min_interval = min_reg;
    assign max_interval = max_reg;
    assign fill_count   = FILL_W'(held);

endmodule

@@ src/fis_history_ring.sv @@
// History ring of the last WINDOW intervals with its write pointer and fill count.
// Depends on fis_pkg for widths and the command struct.
module fis_history_ring
    import fis_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ring_cmd_t                   cmd,
    input  logic [STAMP_W-1:0]          wr_data,
    input  logic [AGE_W-1:0]            rd_age,
    output logic [STAMP_W-1:0]          rd_data,
    output logic [$clog2(WINDOW+1)-1:0] held
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW+1);
    localparam int SUM_W  = ((SLOT_W > AGE_W) ? SLOT_W : AGE_W) + 1;

    logic [STAMP_W-1:0] ring_mem [WINDOW];
    logic [STAMP_W-1:0] q_reg;
    logic               hit_reg;
    logic               hit_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [CNT_W-1:0]   held_reg;
    logic [CNT_W-1:0]   held_next;
    logic               full;
    logic [SUM_W-1:0]   oldest;
    logic [SUM_W-1:0]   raw_slot;
    logic [SLOT_W-1:0]  rd_slot;

    assign full = (held_reg == CNT_W'(WINDOW));

    // Until the ring has wrapped, the oldest entry sits in slot zero.
    // For an age below the count, one subtract brings the sum in range; other ages answer zero.
    assign oldest   = full ? SUM_W'(slot_reg) : '0;
    assign raw_slot = oldest + SUM_W'(rd_age);
    assign rd_slot  = (raw_slot >= SUM_W'(WINDOW)) ? SLOT_W'(raw_slot - SUM_W'(WINDOW))
                                                   : SLOT_W'(raw_slot);

    assign hit_next = cmd.read && (SUM_W'(rd_age) < SUM_W'(held_reg));

    always_comb
    begin
        slot_next = slot_reg;
        held_next = held_reg;
        if (cmd.push)
        begin
            slot_next = (slot_reg == SLOT_W'(WINDOW-1)) ? '0 : slot_reg + 1'b1;
            if (!full)
            begin
                held_next = held_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            held_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            held_reg <= held_next;
            if (cmd.take)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    // Writes and reads come from different transactions, so a read never
    // overlaps a write to the same entry and needs no forwarding.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_mem[slot_reg] <= wr_data;
        end
        if (cmd.read)
        begin
            q_reg <= ring_mem[rd_slot];
        end
    end

    assign rd_data = hit_reg ? q_reg : '0;
    assign held    = held_reg;

endmodule

@@ src/fis_checker.sv @@
// Port-level checker for frame_interval_stats_unit, attached with a bind.
// Depends on fis_pkg for widths.
module fis_checker
    import fis_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [STAMP_W-1:0] min_interval,
    input logic [STAMP_W-1:0] max_interval,
    input logic [FILL_W-1:0]  fill_count,
    input logic [STAMP_W-1:0] history_value
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_interval)
            && $stable(max_interval) && $stable(fill_count) && $stable(history_value))
    else $error("result changed while stalled");

    // With no result pending, an offered transaction is always taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_valid |-> in_ready)
    else $error("input refused while empty");

    // The maximum bounds every interval, including the minimum.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> max_interval >= min_interval)
    else $error("minimum above maximum");

    // For WINDOW up to 15, the fill count only grows until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (WINDOW > 15) || (fill_count >= $past(fill_count)))
    else $error("fill count decreased");

    // An empty ring can only answer zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fill_count == '0) && (WINDOW < 16) |-> history_value == '0)
    else $error("history data from an empty ring");

endmodule

bind frame_interval_stats_unit fis_checker #(
    .WINDOW (WINDOW)
) u_fis_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .min_interval  (min_interval),
    .max_interval  (max_interval),
    .fill_count    (fill_count),
    .history_value (history_value)
);
